### sv/b64dns_pkg.sv
package b64dns_pkg;

    localparam int LabelMaxDef   = 63;
    localparam int MaxEncodedDef = 255;
    localparam int QueueDepth    = 2;
    localparam int QueueAw       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QueueCw       = $clog2(QueueDepth + 1);
    localparam int MaxChars      = 4;

    localparam logic [7:0] PadChar = 8'h3d;

    // one request's worth of base64 characters, handed from front to back
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [2:0]               cnt;
        logic                     last;
        logic [7:0]               total;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] c;
        c = {2'b00, idx};
        if (idx < 6'd26) begin
            return 8'd65 + c;
        end else if (idx < 6'd52) begin
            return 8'd71 + c;
        end else if (idx < 6'd62) begin
            return c - 8'd4;
        end else if (idx == 6'd62) begin
            return 8'h2b;
        end
        return 8'h2f;
    endfunction

endpackage

### sv/base64_dns_label_encoder_top.sv
// the first byte of a request passes the job queue and then the output register before it shows on o_out_byte
// throughput: one output byte per cycle while pop is held; a request yields 0 to 6 output bytes
// (none when absorbed, else one to four chars plus a length byte ahead of each label)
// the front takes one request per cycle while the two-entry job queue has room
// reset is synchronous, active low: clears message length, counters, queue and output
module base64_dns_label_encoder_top import b64dns_pkg::*; #(
    parameter int LABEL_MAX   = LabelMaxDef,
    parameter int MAX_ENCODED = MaxEncodedDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte
);

    logic accept;
    logic job_push;
    t_job front_job;
    logic q_full;
    logic q_valid;
    t_job q_job;
    logic job_take;
    logic out_valid;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    b64dns_front #(
        .MAX_ENCODED(MAX_ENCODED)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_job_push  (job_push),
        .o_job       (front_job)
    );

    b64dns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_take  (job_take),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64dns_back #(
        .LABEL_MAX(LABEL_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_take  (job_take),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_out_byte  (o_out_byte)
    );

endmodule

### sv/b64dns_front.sv
module b64dns_front import b64dns_pkg::*; #(
    parameter int MAX_ENCODED = MaxEncodedDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    output logic       o_job_push,
    output t_job       o_job
);

    localparam logic [1:0] Phase0 = 2'd0;
    localparam logic [1:0] Phase1 = 2'd1;
    localparam logic [1:0] Phase2 = 2'd2;
    localparam logic [8:0] MaxEnc = 9'(MAX_ENCODED);

    logic [7:0]  r_msg_len;
    logic [7:0]  r_total;
    logic        r_active;
    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_carry, n_carry;
    logic [7:0]  r_seen,  n_seen;

    logic [8:0]  cfg_plus2;
    logic [19:0] cfg_prod;
    logic [6:0]  cfg_groups;
    logic [8:0]  cfg_total;
    logic        last;

    // ceil(len/3)*4, divide by 3 as multiply by 683 and shift by 11
    assign cfg_plus2  = {1'b0, i_cfg_wdata} + 9'd2;
    assign cfg_prod   = {11'd0, cfg_plus2} * 20'd683;
    assign cfg_groups = cfg_prod[17:11];
    assign cfg_total  = {cfg_groups, 2'b00};

    assign last = ({1'b0, r_seen} + 9'd1) >= {1'b0, r_msg_len};

    always_comb begin
        o_job.chars = '0;
        o_job.cnt   = 3'd1;
        o_job.last  = last;
        o_job.total = r_total;
        n_phase     = r_phase;
        n_carry     = r_carry;
        case (r_phase)
            Phase0: begin
                o_job.chars[0] = b64_char(i_data_byte[7:2]);
                o_job.chars[1] = b64_char({i_data_byte[1:0], 4'b0000});
                o_job.chars[2] = PadChar;
                o_job.chars[3] = PadChar;
                o_job.cnt      = last ? 3'd4 : 3'd1;
                n_phase        = Phase1;
                n_carry        = {2'b00, i_data_byte[1:0]};
            end
            Phase1: begin
                o_job.chars[0] = b64_char({r_carry[1:0], i_data_byte[7:4]});
                o_job.chars[1] = b64_char({i_data_byte[3:0], 2'b00});
                o_job.chars[2] = PadChar;
                o_job.cnt      = last ? 3'd3 : 3'd1;
                n_phase        = Phase2;
                n_carry        = i_data_byte[3:0];
            end
            default: begin
                o_job.chars[0] = b64_char({r_carry, i_data_byte[7:6]});
                o_job.chars[1] = b64_char(i_data_byte[5:0]);
                o_job.cnt      = 3'd2;
                n_phase        = Phase0;
                n_carry        = 4'd0;
            end
        endcase
        // absorbed bytes keep the group position, a final one still clears the back
        if (!r_active) begin
            o_job.cnt = 3'd0;
            n_phase   = r_phase;
            n_carry   = r_carry;
        end
        n_seen = r_seen + 8'd1;
        if (last) begin
            n_phase = Phase0;
            n_carry = 4'd0;
            n_seen  = 8'd0;
        end
    end

    assign o_job_push = i_accept && (r_active || last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len <= 8'd0;
            r_total   <= 8'd0;
            r_active  <= 1'b0;
            r_phase   <= Phase0;
            r_carry   <= 4'd0;
            r_seen    <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_msg_len <= i_cfg_wdata;
                r_total   <= cfg_total[7:0];
                r_active  <= (cfg_total != 9'd0) && (cfg_total <= MaxEnc);
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_carry <= n_carry;
                r_seen  <= n_seen;
            end
        end
    end

endmodule

### sv/b64dns_queue.sv
module b64dns_queue import b64dns_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_take,
    output logic o_valid,
    output t_job o_job
);

    t_job               r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wr_ptr;
    logic [QueueAw-1:0] r_rd_ptr;
    logic [QueueCw-1:0] r_count;

    localparam logic [QueueAw-1:0] PtrLast = QueueAw'(QueueDepth - 1);
    localparam logic [QueueCw-1:0] CntFull = QueueCw'(QueueDepth);

    logic do_push, do_take;

    assign o_full  = (r_count == CntFull);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_take) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_take) begin
                r_count <= r_count + 1'b1;
            end else if (do_take && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/b64dns_back.sv
module b64dns_back import b64dns_pkg::*; #(
    parameter int LABEL_MAX = LabelMaxDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_take,
    input  logic       i_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte
);

    localparam int LabEff = (LABEL_MAX < 2) ? 2 : LABEL_MAX;
    localparam int LabW   = $clog2(LabEff);
    localparam logic [7:0]      LabByte = 8'(LabEff);
    localparam logic [LabW-1:0] LabLast = LabW'(LabEff - 1);

    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_byte,  n_out_byte;
    logic [1:0]      r_idx,       n_idx;
    logic            r_len_done,  n_len_done;
    logic [7:0]      r_chars,     n_chars;
    logic [LabW-1:0] r_lab_cnt,   n_lab_cnt;

    logic       job_nop;
    logic       advance;
    logic       need_len;
    logic       job_end;
    logic [7:0] rem;
    logic [7:0] len_byte;

    assign job_nop  = (i_job.cnt == 3'd0);
    assign advance  = i_job_valid && !job_nop && (!r_out_valid || i_pop);
    assign need_len = (r_lab_cnt == '0) && !r_len_done;
    assign job_end  = !need_len && (({1'b0, r_idx} + 3'd1) == i_job.cnt);
    assign rem      = (i_job.total > r_chars) ? (i_job.total - r_chars) : 8'd0;
    assign len_byte = (rem < LabByte) ? rem : LabByte;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_idx       = r_idx;
        n_len_done  = r_len_done;
        n_chars     = r_chars;
        n_lab_cnt   = r_lab_cnt;
        o_job_take  = 1'b0;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (i_job_valid && job_nop) begin
            // final byte of an absorbed message only restarts the label count
            o_job_take = 1'b1;
            n_idx      = 2'd0;
            n_chars    = 8'd0;
            n_lab_cnt  = '0;
        end else if (advance) begin
            n_out_valid = 1'b1;
            if (need_len) begin
                // label length byte goes ahead of the first char of each label
                n_out_byte = len_byte;
                n_len_done = 1'b1;
            end else begin
                n_out_byte = i_job.chars[r_idx];
                n_len_done = 1'b0;
                n_chars    = r_chars + 8'd1;
                n_lab_cnt  = (r_lab_cnt == LabLast) ? '0 : r_lab_cnt + 1'b1;
                n_idx      = r_idx + 2'd1;
                if (job_end) begin
                    o_job_take = 1'b1;
                    n_idx      = 2'd0;
                    if (i_job.last) begin
                        n_chars   = 8'd0;
                        n_lab_cnt = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_len_done  <= 1'b0;
            r_chars     <= 8'd0;
            r_lab_cnt   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_len_done  <= n_len_done;
            r_chars     <= n_chars;
            r_lab_cnt   <= n_lab_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

endmodule

### sv/b64dns_checker.sv
module b64dns_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte
);

    // output is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // a waiting byte holds until taken
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)))
        else $error("waiting output changed");

    // only length bytes, base64 chars or padding come out
    a_out_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_out_byte <= 8'd63) || (o_out_byte == 8'h3d)
                    || ((o_out_byte >= 8'h41) && (o_out_byte <= 8'h5a))
                    || ((o_out_byte >= 8'h61) && (o_out_byte <= 8'h7a))))
        else $error("illegal output byte");

    // the queue only fills up from accepted requests
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a request");

endmodule

bind base64_dns_label_encoder_top b64dns_checker u_b64dns_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte)
);

### tb/tb_base64_dns_label_encoder_top.sv
`timescale 1ns / 100ps

module tb_base64_dns_label_encoder_top;
    import b64dns_pkg::*;

    localparam int StallLimit = 2000;
    localparam int SettleCycles = 16;
    localparam int RandItems = 20;

    // predicts the encoded stream and holds the characters still owed by the block
    class encoder_scoreboard;
        string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        logic [7:0] msg_len;
        logic [1:0] phase;
        logic [3:0] carry;
        logic [7:0] seen;
        logic [7:0] emitted;
        logic [7:0] pending_chars[$];
        int errors;

        function new();
            msg_len = 8'd0;
            phase = 2'd0;
            carry = 4'd0;
            seen = 8'd0;
            emitted = 8'd0;
            errors = 0;
        endfunction

        function void set_length(logic [7:0] v);
            msg_len = v;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function logic [7:0] sextet(logic [5:0] idx);
            return alphabet[idx];
        endfunction

        // a label length byte goes ahead of every label's first character
        function void emit(int total, logic [7:0] c);
            int lab;
            int rem;
            lab = (LabelMaxDef < 2) ? 2 : LabelMaxDef;
            if ((int'(emitted) % lab) == 0) begin
                rem = (total > int'(emitted)) ? total - int'(emitted) : 0;
                pending_chars.push_back(8'((rem < lab) ? rem : lab));
            end
            pending_chars.push_back(c);
            emitted = emitted + 8'd1;
        endfunction

        function void note_request(logic [7:0] b);
            int total;
            bit active;
            bit last;
            total = ((int'(msg_len) + 2) / 3) * 4;
            active = (total != 0) && (total <= MaxEncodedDef);
            last = (int'(seen) + 1) >= int'(msg_len);
            if (active) begin
                case (phase)
                    2'd0: begin
                        emit(total, sextet(b[7:2]));
                        carry = {2'b00, b[1:0]};
                        phase = 2'd1;
                    end
                    2'd1: begin
                        emit(total, sextet({carry[1:0], b[7:4]}));
                        carry = b[3:0];
                        phase = 2'd2;
                    end
                    default: begin
                        emit(total, sextet({carry, b[7:6]}));
                        emit(total, sextet(b[5:0]));
                        carry = 4'd0;
                        phase = 2'd0;
                    end
                endcase
                // flush the partial group with padding
                if (last) begin
                    if (phase == 2'd1) begin
                        emit(total, sextet({carry[1:0], 4'b0000}));
                        emit(total, PadChar);
                        emit(total, PadChar);
                    end else if (phase == 2'd2) begin
                        emit(total, sextet({carry, 2'b00}));
                        emit(total, PadChar);
                    end
                end
            end
            if (last) begin
                phase = 2'd0;
                carry = 4'd0;
                seen = 8'd0;
                emitted = 8'd0;
            end else begin
                seen = seen + 8'd1;
            end
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: out_byte unexpected, expected none, actual %02h", $time, got);
            end else begin
                want = pending_chars.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want, got);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       push;
    logic       full;
    logic [7:0] i_data_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;

    encoder_scoreboard sb = new();
    bit no_idle;
    int idle_cycles;
    int rand_items;

    base64_dns_label_encoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // push stays high across back-to-back requests
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push = 1'b1;
        i_data_byte = b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(b);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    // absorbed bytes leave no trace, so give the block time to settle after the last char
    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [7:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        sb.set_length(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        no_idle = ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        int gap;
        int burst;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                pop = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst = $urandom_range(1, 12);
            @(negedge i_clk);
            pop = 1'b1;
            repeat (burst - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_out_byte);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("FAIL base64_dns_label_encoder_top");
            $finish;
        end
    end

    initial begin
        int r;
        int len;
        int n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'd0;
        push = 1'b0;
        i_data_byte = 8'd0;
        no_idle = 1'b0;
        idle_cycles = 0;
        rand_items = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message: everything absorbed
        write_length(8'd0);
        send_byte(8'h00);
        send_byte(8'hff);
        // one and two bytes, double and single padding
        write_length(8'd1);
        send_byte(8'hff);
        write_length(8'd2);
        send_byte(8'h00);
        send_byte(8'h00);
        // full groups, '+' and '/' and the low end of the alphabet
        write_length(8'd3);
        send_byte(8'hfb);
        send_byte(8'hff);
        send_byte(8'hbf);
        write_length(8'd3);
        send_byte(8'h00);
        send_byte(8'h10);
        send_byte(8'h83);
        // length cut short mid-message
        write_length(8'd5);
        send_byte(8'h12);
        send_byte(8'h34);
        write_length(8'd2);
        send_byte(8'h56);
        write_length(8'd4);
        send_byte(8'h7f);
        write_length(8'd1);
        send_byte(8'h80);
        // too long, still too long after shortening, then shortened so the next byte ends the message
        write_length(8'd255);
        send_random(3);
        write_length(8'd190);
        send_byte(8'h01);
        write_length(8'd1);
        send_byte(8'hc3);
        // a message ended by an absorbed byte starts the next one on a fresh label
        write_length(8'd4);
        send_byte(8'h9a);
        send_byte(8'h5c);
        write_length(8'd0);
        send_byte(8'h11);
        write_length(8'd1);
        send_byte(8'h22);
        // largest length that still encodes, ended early
        write_length(8'd189);
        send_random(3);
        write_length(8'd4);
        send_random(1);

        // shrink after 62 chars so the next label length comes out zero
        write_length(8'd60);
        send_random(47);
        write_length(8'd45);
        send_random(1);

        while (rand_items < RandItems) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                len = $urandom_range(1, 12);
                n = len;
            end else if (r < 70) begin
                len = $urandom_range(13, 62);
                n = len;
            end else if (r < 78) begin
                len = 0;
                n = $urandom_range(1, 3);
            end else if (r < 86) begin
                len = $urandom_range(190, 255);
                n = $urandom_range(1, 5);
            end else begin
                // broken message, the next length write lands mid-message
                len = $urandom_range(2, 30);
                n = $urandom_range(1, len - 1);
            end
            write_length(8'(len));
            send_random(n);
            if (len >= 1 && len <= 189) begin
                rand_items += n;
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS base64_dns_label_encoder_top");
        end else begin
            $display("FAIL base64_dns_label_encoder_top");
        end
        $finish;
    end

endmodule
